>>> hdl/xfec_pkg.sv
// Package for the XOR FEC packet history buffer: transaction payload types,
// sizing constants, the FEC reciprocal and the controller/datapath command types.
// No dependencies.
`default_nettype none

package xfec_pkg;

  // Field widths of the transactions.
  localparam int SEQ_W  = 32;
  localparam int IDX_W  = 5;
  localparam int WORD_W = 64;

  // Ring of packet slots. The depth must be a power of two so that the
  // slot of a sequence number is its low bits.
  localparam int RING_DEPTH    = 1024;
  localparam int PAYLOAD_WORDS = 20;
  localparam int SLOT_W        = $clog2(RING_DEPTH);
  localparam int STORE_DEPTH   = RING_DEPTH * PAYLOAD_WORDS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // Parity is left out on every FEC_PERIOD-th packet. The remainder of
  // seq by the period uses a reciprocal multiply with one correction.
  localparam int FEC_PERIOD = 25;
  localparam int FEC_W      = 16;
  localparam int FEC_LOG    = $clog2(FEC_PERIOD);
  localparam int FEC_SHIFT  = SEQ_W + FEC_LOG;
  localparam int RECIP_W    = SEQ_W + 1;
  localparam int PROD_W     = SEQ_W + FEC_SHIFT;
  localparam logic [63:0] FEC_RECIP_FULL = (64'd1 << FEC_SHIFT) / 64'(FEC_PERIOD);
  localparam logic [RECIP_W-1:0] FEC_RECIP = FEC_RECIP_FULL[RECIP_W-1:0];

  // Opcodes and result kinds.
  localparam logic OP_SOURCE  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;
  localparam logic KIND_FRESH  = 1'b0;
  localparam logic KIND_REPLAY = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SEQ_W-1:0]  seq;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [IDX_W-1:0]  out_index;
    logic [WORD_W-1:0] payload_word;
    logic [WORD_W-1:0] parity_word;
    logic              parity_present;
    logic              last;
  } out_item_t;

  // Which slot the store and valid map are read from.
  typedef enum logic [1:0] {
    RD_S1   = 2'd0,
    RD_S2   = 2'd1,
    RD_SLOT = 2'd2,
    RD_WORD = 2'd3
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    clr_step;
    logic    wr_store;
    logic    set_valid;
    logic    rd_store;
    logic    rd_valid;
    rd_sel_t rd_sel;
    logic    calc_q;
    logic    calc_qp;
    logic    calc_rem;
    logic    acc_s1;
    logic    acc_s2;
    logic    emit_fresh;
    logic    emit_replay;
    logic    k_clear;
    logic    k_inc;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_req;
    logic in_idx_ok;
    logic clr_done;
    logic valid_bit;
    logic is_last_word;
    logic k_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/xor_fec_packet_history_buffer.sv
// Top level of the XOR FEC packet history buffer; joins xfec_ctrl and xfec_dp (xfec_pkg).
// Source word: accepted in idle; F_RD1, F_RD2 and F_ACC follow, and F_EMIT loads the result
// once the output is free; the next word is taken only after that. The two neighbor-slot reads
// are sequential on the store's one read port. Retransmit of a valid slot: 20 results, each a
// store read, then an output load that waits for a free output; an invalid slot yields none.
// Synchronous active-low reset; a sweep then clears the valid map while in_ready stays low.
`default_nettype none

module xor_fec_packet_history_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xfec_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xfec_pkg::out_item_t out_data
);
  import xfec_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  xfec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xfec_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> hdl/xfec_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module xfec_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/xfec_ctrl.sv
// Controller state machine of the XOR FEC history buffer.
// Depends on xfec_pkg for the command and status types.
`default_nettype none

module xfec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  xfec_pkg::dp_sts_t sts,
  output xfec_pkg::dp_cmd_t cmd
);
  import xfec_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_F_RD1  = 10'b00_0000_0100,
    ST_F_RD2  = 10'b00_0000_1000,
    ST_F_ACC  = 10'b00_0001_0000,
    ST_F_EMIT = 10'b00_0010_0000,
    ST_R_CHK  = 10'b00_0100_0000,
    ST_R_TEST = 10'b00_1000_0000,
    ST_R_RD   = 10'b01_0000_0000,
    ST_R_EMIT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          if (sts.in_is_req) begin
            state_nxt = ST_R_CHK;
          end else if (sts.in_idx_ok) begin
            state_nxt = ST_F_RD1;
          end
        end
      end
      // Store the word, mark the slot on its last word, read slot seq-1.
      ST_F_RD1: begin
        cmd.wr_store  = 1'b1;
        cmd.set_valid = sts.is_last_word;
        cmd.rd_store  = 1'b1;
        cmd.rd_valid  = 1'b1;
        cmd.rd_sel    = RD_S1;
        cmd.calc_q    = 1'b1;
        state_nxt     = ST_F_RD2;
      end
      // Take the seq-1 word, read slot seq-2.
      ST_F_RD2: begin
        cmd.acc_s1   = 1'b1;
        cmd.rd_store = 1'b1;
        cmd.rd_valid = 1'b1;
        cmd.rd_sel   = RD_S2;
        cmd.calc_qp  = 1'b1;
        state_nxt    = ST_F_ACC;
      end
      ST_F_ACC: begin
        cmd.acc_s2   = 1'b1;
        cmd.calc_rem = 1'b1;
        state_nxt    = ST_F_EMIT;
      end
      ST_F_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_fresh = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_R_CHK: begin
        cmd.rd_valid = 1'b1;
        cmd.rd_sel   = RD_SLOT;
        cmd.k_clear  = 1'b1;
        state_nxt    = ST_R_TEST;
      end
      ST_R_TEST: begin
        state_nxt = sts.valid_bit ? ST_R_RD : ST_IDLE;
      end
      ST_R_RD: begin
        cmd.rd_store = 1'b1;
        cmd.rd_sel   = RD_WORD;
        state_nxt    = ST_R_EMIT;
      end
      ST_R_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_replay = 1'b1;
          cmd.k_inc       = 1'b1;
          state_nxt       = sts.k_last ? ST_IDLE : ST_R_RD;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the valid map sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/xfec_dp.sv
// Datapath of the XOR FEC history buffer: input capture, payload store and
// valid map RAMs, parity accumulator, FEC remainder unit and output register.
// Depends on xfec_pkg and xfec_ram.
`default_nettype none

module xfec_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xfec_pkg::in_item_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output xfec_pkg::out_item_t  out_data,
  input  xfec_pkg::dp_cmd_t    cmd,
  output xfec_pkg::dp_sts_t    sts
);
  import xfec_pkg::*;

  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic [SEQ_W-1:0]  q_r, q_nxt;
  logic [SEQ_W-1:0]  qp_r, qp_nxt;
  logic              par_on_r, par_on_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SLOT_W-1:0]  slot, slot_m1, slot_m2;
  logic [ADDR_W-1:0]  st_wr_addr, st_rd_addr;
  logic [SLOT_W-1:0]  vm_wr_addr, vm_rd_addr;
  logic               vm_wr_en;
  logic [WORD_W-1:0]  st_rd_data;
  logic               vm_rd_data;
  logic [PROD_W-1:0]  q_prod;
  logic [SEQ_W+FEC_W-1:0] qp_prod;
  logic [SEQ_W-1:0]   rem;
  logic               use_s1, use_s2, out_free;

  // Slot of the current packet and of its two predecessors.
  assign slot    = seq_r[SLOT_W-1:0];
  assign slot_m1 = slot - SLOT_W'(1);
  assign slot_m2 = slot - SLOT_W'(2);

  // Store address of a word position in a slot.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [IDX_W-1:0] p);
    store_addr = ADDR_W'(s) * ADDR_W'(PAYLOAD_WORDS) + ADDR_W'(p);
  endfunction

  // Read address selection for both RAMs.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_S1: begin
        st_rd_addr = store_addr(slot_m1, idx_r);
        vm_rd_addr = slot_m1;
      end
      RD_S2: begin
        st_rd_addr = store_addr(slot_m2, idx_r);
        vm_rd_addr = slot_m2;
      end
      RD_WORD: begin
        st_rd_addr = store_addr(slot, k_r);
        vm_rd_addr = slot;
      end
      default: begin
        st_rd_addr = store_addr(slot, idx_r);
        vm_rd_addr = slot;
      end
    endcase
  end

  assign st_wr_addr = store_addr(slot, idx_r);
  assign vm_wr_en   = cmd.clr_step | cmd.set_valid;
  assign vm_wr_addr = cmd.clr_step ? clr_cnt_r : slot;

  xfec_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_store),
    .wr_addr (st_wr_addr),
    .wr_data (data_r),
    .rd_en   (cmd.rd_store),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  xfec_ram #(
    .WIDTH (1),
    .DEPTH (RING_DEPTH)
  ) u_valid_map (
    .clk     (clk),
    .wr_en   (vm_wr_en),
    .wr_addr (vm_wr_addr),
    .wr_data (cmd.set_valid),
    .rd_en   (cmd.rd_valid),
    .rd_addr (vm_rd_addr),
    .rd_data (vm_rd_data)
  );

  // FEC remainder: quotient estimate, its product with the period, and a
  // remainder below twice the period, which is zero mod the period when it
  // equals zero or the period itself.
  assign q_prod  = PROD_W'(seq_r) * PROD_W'(FEC_RECIP);
  assign qp_prod = (SEQ_W+FEC_W)'(q_r) * (SEQ_W+FEC_W)'(FEC_PERIOD);
  assign rem     = seq_r - qp_r;

  // A neighbor slot contributes only when valid and its seq does not underflow.
  assign use_s1 = vm_rd_data && (seq_r != '0);
  assign use_s2 = vm_rd_data && (seq_r[SEQ_W-1:1] != '0);

  assign out_free = !out_valid_r || out_ready;

  // Next values of the datapath registers.
  always_comb begin
    seq_nxt       = seq_r;
    idx_nxt       = idx_r;
    data_nxt      = data_r;
    q_nxt         = q_r;
    qp_nxt        = qp_r;
    par_on_nxt    = par_on_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.capture) begin
      seq_nxt  = in_data.seq;
      idx_nxt  = in_data.word_index;
      data_nxt = in_data.data_word;
    end
    if (cmd.calc_q) begin
      q_nxt = q_prod[PROD_W-1:FEC_SHIFT];
    end
    if (cmd.calc_qp) begin
      qp_nxt = qp_prod[SEQ_W-1:0];
    end
    if (cmd.calc_rem) begin
      par_on_nxt = (rem != '0) && (rem != SEQ_W'(FEC_PERIOD));
    end
    if (cmd.acc_s1) begin
      acc_nxt = use_s1 ? st_rd_data : '0;
    end else if (cmd.acc_s2) begin
      acc_nxt = acc_r ^ (use_s2 ? st_rd_data : '0);
    end
    if (cmd.k_clear) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + IDX_W'(1);
    end
    if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
    end

    // Output register: a new result loads, a taken result empties it.
    if (cmd.emit_fresh) begin
      out_nxt.kind           = KIND_FRESH;
      out_nxt.out_seq        = seq_r;
      out_nxt.out_index      = idx_r;
      out_nxt.payload_word   = data_r;
      out_nxt.parity_word    = par_on_r ? acc_r : '0;
      out_nxt.parity_present = par_on_r;
      out_nxt.last           = (idx_r == IDX_W'(PAYLOAD_WORDS - 1));
      out_valid_nxt          = 1'b1;
    end else if (cmd.emit_replay) begin
      out_nxt.kind           = KIND_REPLAY;
      out_nxt.out_seq        = seq_r;
      out_nxt.out_index      = k_r;
      out_nxt.payload_word   = st_rd_data;
      out_nxt.parity_word    = '0;
      out_nxt.parity_present = 1'b0;
      out_nxt.last           = (k_r == IDX_W'(PAYLOAD_WORDS - 1));
      out_valid_nxt          = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    idx_r    <= idx_nxt;
    data_r   <= data_nxt;
    q_r      <= q_nxt;
    qp_r     <= qp_nxt;
    par_on_r <= par_on_nxt;
    acc_r    <= acc_nxt;
    k_r      <= k_nxt;
    out_r    <= out_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Status to the controller.
  assign sts.in_is_req    = (in_data.opcode == OP_REQUEST);
  assign sts.in_idx_ok    = (in_data.word_index < IDX_W'(PAYLOAD_WORDS));
  assign sts.clr_done     = (clr_cnt_r == SLOT_W'(RING_DEPTH - 1));
  assign sts.valid_bit    = vm_rd_data;
  assign sts.is_last_word = (idx_r == IDX_W'(PAYLOAD_WORDS - 1));
  assign sts.k_last       = (k_r == IDX_W'(PAYLOAD_WORDS - 1));
  assign sts.out_free     = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result is only loaded when the output register is free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_fresh || cmd.emit_replay) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  // The valid map sweep never overlaps a store write or a valid-bit set.
  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> (!cmd.wr_store && !cmd.set_valid))
    else $error("store access during valid map sweep");

  // Replayed positions stay inside the payload.
  a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_replay |-> (k_r < IDX_W'(PAYLOAD_WORDS)))
    else $error("replay position out of range");

  // A fresh result is emitted only for a word that was stored.
  a_fresh_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_fresh |-> (idx_r < IDX_W'(PAYLOAD_WORDS)))
    else $error("fresh result for an out-of-range position");

endmodule

`default_nettype wire
